/* design/ray_triangle_intersect_assert.svh */
// Assertion macros shared by the ray/triangle intersection checkers.
`ifndef RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RTI_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ray_triangle_intersect assertion failed");

// Next-cycle implication, disabled during reset.
`define RTI_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ray_triangle_intersect assertion failed");

`endif

/* design/rti_pkg.sv */
// Shared types, widths and constants of the ray/triangle intersection block.
package rti_pkg;

  localparam int CW = 16;
  localparam int EW = CW + 1;
  localparam int PW = 2 * EW;
  localparam int NW = PW + 1;
  localparam int DPW = NW + EW;
  localparam int SW = DPW + 2;
  localparam int QW = CW + 2;
  localparam int RW = SW + QW;
  localparam int HALF = (SW + 1) / 2;
  localparam int LANE_LAT = QW + 5;
  localparam int CFG_IDX_W = 2;
  localparam int VTX_W = 3 * CW;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C = CFG_IDX_W'(2);
  localparam logic [VTX_W-1:0] VERTEX_RESET = VTX_W'(256);

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
  } ray_t;

  typedef struct packed {
    logic   hit;
    logic   parallel;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
  } res_t;

  typedef struct packed {
    logic vld;
    logic hit;
    logic parallel;
  } ctl_t;

  typedef struct packed {
    logic [SW-1:0]        num_mag;
    logic [SW-1:0]        den_mag;
    logic [2:0][CW-1:0]   dir_mag;
    logic [2:0]           neg;
    logic [2:0][CW-1:0]   org;
  } geo_t;

endpackage

/* design/rti_geom.sv */
// Geometry pipeline: normal, plane numerator and denominator, and edge tests.
module rti_geom import rti_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  ray_t             ray,
  input  logic [VTX_W-1:0] vtx_a,
  input  logic [VTX_W-1:0] vtx_b,
  input  logic [VTX_W-1:0] vtx_c,
  output ctl_t             ctl,
  output geo_t             geo
);

  // Cross products: 0 is the face normal, 1..3 are the edge terms.
  localparam int CU [4] = '{0, 2, 3, 4};
  localparam int CV [4] = '{1, 3, 4, 2};
  localparam int NX1 [3] = '{1, 2, 0};
  localparam int NX2 [3] = '{2, 0, 1};

  logic vld1, vld2, vld3, vld4, vld5;

  logic signed [EW-1:0]  e1 [5][3];
  coord_t                p1 [3], p2 [3], p3 [3], p4 [3], p5 [3];
  coord_t                d1 [3], d2 [3], d3 [3], d4 [3], d5 [3];
  logic signed [EW-1:0]  pa2 [3], pa3 [3];
  logic signed [PW-1:0]  pr2 [4][6];
  logic signed [NW-1:0]  cr3 [4][3];
  logic signed [DPW-1:0] dp4 [5][3];
  logic signed [SW-1:0]  s5 [5];

  // Stage 1: edge vectors and vertex offsets from the ray origin.
  always_ff @(posedge clk) begin
    coord_t av, bv, cv;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        av = vtx_a[(2-k)*CW +: CW];
        bv = vtx_b[(2-k)*CW +: CW];
        cv = vtx_c[(2-k)*CW +: CW];
        e1[0][k] <= EW'(bv) - EW'(av);
        e1[1][k] <= EW'(cv) - EW'(av);
      end
      e1[2][0] <= EW'(coord_t'(vtx_a[2*CW +: CW])) - EW'(ray.origin_x);
      e1[2][1] <= EW'(coord_t'(vtx_a[CW +: CW])) - EW'(ray.origin_y);
      e1[2][2] <= EW'(coord_t'(vtx_a[0 +: CW])) - EW'(ray.origin_z);
      e1[3][0] <= EW'(coord_t'(vtx_b[2*CW +: CW])) - EW'(ray.origin_x);
      e1[3][1] <= EW'(coord_t'(vtx_b[CW +: CW])) - EW'(ray.origin_y);
      e1[3][2] <= EW'(coord_t'(vtx_b[0 +: CW])) - EW'(ray.origin_z);
      e1[4][0] <= EW'(coord_t'(vtx_c[2*CW +: CW])) - EW'(ray.origin_x);
      e1[4][1] <= EW'(coord_t'(vtx_c[CW +: CW])) - EW'(ray.origin_y);
      e1[4][2] <= EW'(coord_t'(vtx_c[0 +: CW])) - EW'(ray.origin_z);
      p1[0] <= ray.origin_x;
      p1[1] <= ray.origin_y;
      p1[2] <= ray.origin_z;
      d1[0] <= ray.dir_x;
      d1[1] <= ray.dir_y;
      d1[2] <= ray.dir_z;
    end
  end

  // Stage 2: the partial products of the four cross products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        for (int j = 0; j < 3; j++) begin
          pr2[c][2*j]   <= PW'(e1[CU[c]][NX1[j]] * e1[CV[c]][NX2[j]]);
          pr2[c][2*j+1] <= PW'(e1[CU[c]][NX2[j]] * e1[CV[c]][NX1[j]]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        pa2[k] <= e1[2][k];
        p2[k]  <= p1[k];
        d2[k]  <= d1[k];
      end
    end
  end

  // Stage 3: cross product components.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        for (int j = 0; j < 3; j++) begin
          cr3[c][j] <= NW'(pr2[c][2*j]) - NW'(pr2[c][2*j+1]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        pa3[k] <= pa2[k];
        p3[k]  <= p2[k];
        d3[k]  <= d2[k];
      end
    end
  end

  // Stage 4: dot product terms; row 4 is the plane numerator N.(A-p).
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 3; k++) begin
          dp4[c][k] <= DPW'(cr3[c][k] * d3[k]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        dp4[4][k] <= DPW'(cr3[0][k] * pa3[k]);
        p4[k]     <= p3[k];
        d4[k]     <= d3[k];
      end
    end
  end

  // Stage 5: dot product sums.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 5; c++) begin
        s5[c] <= SW'(dp4[c][0]) + SW'(dp4[c][1]) + SW'(dp4[c][2]);
      end
      for (int k = 0; k < 3; k++) begin
        p5[k] <= p4[k];
        d5[k] <= d4[k];
      end
    end
  end

  // Stage 6: decisions and magnitudes for the divider lanes.
  always_ff @(posedge clk) begin
    logic den_neg, par, miss;
    if (en) begin
      den_neg = s5[0][SW-1];
      par     = (s5[0] == '0);
      miss    = 1'b0;
      for (int c = 1; c < 4; c++) begin
        miss = miss | ((s5[c] != '0) && (s5[c][SW-1] ^ den_neg));
      end
      ctl.hit      <= !par && !miss;
      ctl.parallel <= par;
      geo.num_mag  <= s5[4][SW-1] ? SW'(-s5[4]) : SW'(s5[4]);
      geo.den_mag  <= den_neg ? SW'(-s5[0]) : SW'(s5[0]);
      for (int k = 0; k < 3; k++) begin
        geo.dir_mag[k] <= d5[k][CW-1] ? CW'(-d5[k]) : CW'(d5[k]);
        geo.neg[k]     <= s5[4][SW-1] ^ den_neg ^ d5[k][CW-1];
        geo.org[k]     <= p5[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      vld4    <= 1'b0;
      vld5    <= 1'b0;
      ctl.vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      vld3    <= vld2;
      vld4    <= vld3;
      vld5    <= vld4;
      ctl.vld <= vld5;
    end
  end

endmodule

/* design/rti_lane.sv */
// One coordinate lane: scaled offset by long division, rounding and saturation.
module rti_lane import rti_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [SW-1:0] num_mag,
  input  logic [CW-1:0] dir_mag,
  input  logic [SW-1:0] den_mag,
  input  logic          neg,
  input  coord_t        org,
  output coord_t        coord
);

  logic [HALF+CW-1:0]    lo1;
  logic [SW-HALF+CW-1:0] hi1;
  logic [SW-1:0]         dv1, dv2;
  logic                  ng1, ng2;
  coord_t                og1, og2;
  logic [RW-1:0]         prod2;

  logic [RW-1:0] rem [QW+1];
  logic [QW-1:0] quo [QW+1];
  logic [SW-1:0] dv  [QW+1];
  logic          sat [QW+1];
  logic          ng  [QW+1];
  coord_t        og  [QW+1];
  logic [RW:0]   trial [QW];

  logic [QW:0] qr;
  logic        sat_r, ng_r;
  coord_t      og_r;

  // Product split into two narrow partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      lo1 <= (HALF+CW)'(num_mag[HALF-1:0] * dir_mag);
      hi1 <= (SW-HALF+CW)'(num_mag[SW-1:HALF] * dir_mag);
      dv1 <= den_mag;
      ng1 <= neg;
      og1 <= org;
      prod2 <= (RW'(hi1) << HALF) + RW'(lo1);
      dv2   <= dv1;
      ng2   <= ng1;
      og2   <= og1;
    end
  end

  // Any quotient of 2^QW or more pushes the point past the output range.
  always_ff @(posedge clk) begin
    if (en) begin
      sat[0] <= (prod2 >= (RW'(dv2) << QW));
      rem[0] <= prod2;
      quo[0] <= '0;
      dv[0]  <= dv2;
      ng[0]  <= ng2;
      og[0]  <= og2;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  always_comb begin
    for (int k = 1; k <= QW; k++) begin
      trial[k-1] = {1'b0, rem[k-1]} - ({1'b0, RW'(dv[k-1])} << (QW - k));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= QW; k++) begin
        rem[k] <= trial[k-1][RW] ? rem[k-1] : trial[k-1][RW-1:0];
        quo[k] <= {quo[k-1][QW-2:0], !trial[k-1][RW]};
        dv[k]  <= dv[k-1];
        sat[k] <= sat[k-1];
        ng[k]  <= ng[k-1];
        og[k]  <= og[k-1];
      end
    end
  end

  // Round half away from zero on the magnitude.
  always_ff @(posedge clk) begin
    logic rnd;
    if (en) begin
      rnd   = ({rem[QW][SW-1:0], 1'b0} >= {1'b0, dv[QW]});
      qr    <= {1'b0, quo[QW]} + (QW+1)'(rnd);
      sat_r <= sat[QW];
      ng_r  <= ng[QW];
      og_r  <= og[QW];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [QW+1:0] offs, sum;
    if (en) begin
      offs = ng_r ? -$signed((QW+2)'(qr)) : $signed((QW+2)'(qr));
      sum  = (QW+2)'(og_r) + offs;
      if (sat_r) begin
        coord <= ng_r ? COORD_MIN : COORD_MAX;
      end else if (sum > (QW+2)'(COORD_MAX)) begin
        coord <= COORD_MAX;
      end else if (sum < (QW+2)'(COORD_MIN)) begin
        coord <= COORD_MIN;
      end else begin
        coord <= CW'(sum);
      end
    end
  end

endmodule

/* design/ray_triangle_intersect.sv */
// Top level of the pipelined ray/triangle intersection block.
//
//   channel | valid / ready          | payload              | direction
//   --------+------------------------+----------------------+----------
//   ray     | ray_valid / ray_ready  | ray (ray_t)          | in
//   res     | res_valid / res_ready  | res (res_t)          | out
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data  | in
//
// One ray is accepted per cycle while ray_ready is high; the depth of the
// pipeline from a transaction to its result is set by the six geometry
// stages, the one-bit-per-stage dividers in the lanes and the output register.
// Reset clears all valid bits and loads every vertex with (0, 0, 1.0).
// A stalled output fills a one-entry skid register; while it is full the
// whole pipeline holds and ray_ready is low. Configuration is always ready.
module ray_triangle_intersect import rti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ray_valid,
  output logic                 ray_ready,
  input  ray_t                 ray,
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_t                 res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VTX_W-1:0]     cfg_data
);

  logic [VTX_W-1:0] vertex_a, vertex_b, vertex_c;

  logic   adv;
  ctl_t   gctl;
  geo_t   geo;
  ctl_t   ctl_line [LANE_LAT];
  coord_t coord [3];
  res_t   last, skid;
  logic   skid_vld;
  logic   take;

  assign cfg_ready = 1'b1;

  // The triangle registers; writes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_a <= VERTEX_RESET;
      vertex_b <= VERTEX_RESET;
      vertex_c <= VERTEX_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_VERTEX_A: vertex_a <= cfg_data;
        REG_VERTEX_B: vertex_b <= cfg_data;
        REG_VERTEX_C: vertex_c <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the skid register is empty, so the item in
  // the last stage always has a place to go.
  assign adv       = !skid_vld;
  assign ray_ready = adv;

  rti_geom u_geom (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .in_vld (ray_valid),
    .ray    (ray),
    .vtx_a  (vertex_a),
    .vtx_b  (vertex_b),
    .vtx_c  (vertex_c),
    .ctl    (gctl),
    .geo    (geo)
  );

  // Lane 0 carries x, lane 1 y and lane 2 z.
  for (genvar k = 0; k < 3; k++) begin : g_lane
    rti_lane u_lane (
      .clk     (clk),
      .en      (adv),
      .num_mag (geo.num_mag),
      .dir_mag (geo.dir_mag[k]),
      .den_mag (geo.den_mag),
      .neg     (geo.neg[k]),
      .org     (coord_t'(geo.org[k])),
      .coord   (coord[k])
    );
  end

  // The hit and parallel flags ride alongside the lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        ctl_line[i] <= '0;
      end
    end else if (adv) begin
      ctl_line[0] <= gctl;
      for (int i = 1; i < LANE_LAT; i++) begin
        ctl_line[i] <= ctl_line[i-1];
      end
    end
  end

  // A miss and a parallel ray both report a zero point.
  always_comb begin
    last.hit      = ctl_line[LANE_LAT-1].hit;
    last.parallel = ctl_line[LANE_LAT-1].parallel;
    last.point_x  = last.hit ? coord[0] : coord_t'(0);
    last.point_y  = last.hit ? coord[1] : coord_t'(0);
    last.point_z  = last.hit ? coord[2] : coord_t'(0);
  end

  assign take = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (skid_vld) begin
      if (take) begin
        skid_vld <= 1'b0;
      end
    end else if (ctl_line[LANE_LAT-1].vld) begin
      if (!res_valid || take) begin
        res_valid <= 1'b1;
      end else begin
        skid_vld <= 1'b1;
      end
    end else if (take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (take) begin
        res <= skid;
      end
    end else if (ctl_line[LANE_LAT-1].vld) begin
      if (!res_valid || take) begin
        res <= last;
      end else begin
        skid <= last;
      end
    end
  end

endmodule

/* design/rti_checker.sv */
// Port-level checker for the ray/triangle intersection block, with its bind.
`include "ray_triangle_intersect_assert.svh"

module rti_checker import rti_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 ray_valid,
  input logic                 ray_ready,
  input ray_t                 ray,
  input logic                 res_valid,
  input logic                 res_ready,
  input res_t                 res,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [VTX_W-1:0]     cfg_data
);

  // A waiting result holds until the transaction completes.
  `RTI_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res))

  // A ray is never both a hit and parallel.
  `RTI_ASSERT_IMP(a_flags_excl, clk, rst, res_valid, !(res.hit && res.parallel))

  // Without a hit the point is all zero.
  `RTI_ASSERT_IMP(a_miss_zero, clk, rst, res_valid && !res.hit, res[3*CW-1:0] == '0)

  // Configuration writes never stall.
  `RTI_ASSERT_IMP(a_cfg_ready, clk, rst, cfg_valid, cfg_ready)

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (.*);

/* bench/tb_top.sv */
// Self-checking testbench for the ray/triangle intersection block.
`timescale 1ns / 1ps

module tb_top;
  import rti_pkg::*;

  // Cycles without any transaction on any channel before the run is abandoned.
  // The slowest correct stretch is a full pipeline drain behind a receiver
  // stall, so this leaves a wide margin.
  localparam int STALL_LIMIT = 3000;
  // Settle time at the end of the run: the pipeline depth plus some margin.
  localparam int DRAIN_CYCLES = 40;
  localparam int NUM_PHASES = 8;
  localparam int RAYS_PER_PHASE = 192;
  localparam longint OFFSET_CAP = 64'd1 << 40;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } vec_t;

  // One row of the directed stimulus. When known is set, the expected result
  // is written into the row; otherwise it comes from the predictor.
  typedef struct {
    ray_t r;
    bit   known;
    res_t e;
  } ray_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 ray_valid = 1'b0;
  logic                 ray_ready;
  ray_t                 ray = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  res_t                 res;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_VERTEX_A;
  logic [VTX_W-1:0]     cfg_data = '0;

  // Local copy of the three vertex registers, updated on each config transaction.
  logic [VTX_W-1:0] vertex_regs [3];
  // Results still owed by the block, oldest first.
  res_t pending_hits [$];
  ray_row_t directed_rays [$];
  int mismatches = 0;
  // Idling on both sides is switched off for the final phase.
  bit idle_on = 1'b1;

  ray_triangle_intersect u_top (
    .clk       (clk),
    .rst       (rst),
    .ray_valid (ray_valid),
    .ray_ready (ray_ready),
    .ray       (ray),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: exact integer geometry at 64 bits, which is wide enough for
  // 16-bit coordinates (the largest triple product needs about 52 bits).
  // ---------------------------------------------------------------------------

  function automatic vec_t vsub(vec_t a, vec_t b);
    vec_t v;
    v.x = a.x - b.x;
    v.y = a.y - b.y;
    v.z = a.z - b.z;
    return v;
  endfunction

  function automatic vec_t vcross(vec_t a, vec_t b);
    vec_t v;
    v.x = a.y * b.z - a.z * b.y;
    v.y = a.z * b.x - a.x * b.z;
    v.z = a.x * b.y - a.y * b.x;
    return v;
  endfunction

  function automatic longint vdot(vec_t a, vec_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  function automatic int sign_of(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic vec_t vertex_of(logic [VTX_W-1:0] w);
    vec_t v;
    v.x = longint'(coord_t'(w[3*CW-1:2*CW]));
    v.y = longint'(coord_t'(w[2*CW-1:CW]));
    v.z = longint'(coord_t'(w[CW-1:0]));
    return v;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v < longint'(COORD_MIN)) return longint'(COORD_MIN);
    if (v > longint'(COORD_MAX)) return longint'(COORD_MAX);
    return v;
  endfunction

  // One coordinate of the hit point: p + round(num * d / den), where the
  // offset magnitude rounds half away from zero and is capped at 2^40
  // before the sum saturates to the coordinate range.
  function automatic coord_t hit_coord(longint p, longint num, longint den, longint d);
    logic [127:0] prod;
    logic [127:0] quo;
    logic [127:0] rem;
    logic [127:0] div;
    longint off;
    prod = 128'(num < 0 ? -num : num) * 128'(d < 0 ? -d : d);
    div = 128'(den < 0 ? -den : den);
    quo = prod / div;
    rem = prod % div;
    if (2 * rem >= div) quo = quo + 1;
    if (quo > 128'(OFFSET_CAP)) quo = 128'(OFFSET_CAP);
    off = longint'(quo[63:0]);
    if (sign_of(num) * sign_of(den) * sign_of(d) < 0) off = -off;
    return coord_t'(clamp_coord(p + off));
  endfunction

  // Expected result of one ray against the current triangle.
  function automatic res_t trace_ray(ray_t r);
    vec_t a, b, c, p, d, n, pa, pb, pc;
    longint den, num;
    int s;
    res_t o;
    o = '0;
    a = vertex_of(vertex_regs[0]);
    b = vertex_of(vertex_regs[1]);
    c = vertex_of(vertex_regs[2]);
    p.x = longint'(r.origin_x);
    p.y = longint'(r.origin_y);
    p.z = longint'(r.origin_z);
    d.x = longint'(r.dir_x);
    d.y = longint'(r.dir_y);
    d.z = longint'(r.dir_z);
    n = vcross(vsub(b, a), vsub(c, a));
    den = vdot(n, d);
    // A ray parallel to the plane, or a degenerate triangle, has no crossing.
    if (den == 0) begin
      o.parallel = 1'b1;
      return o;
    end
    pa = vsub(a, p);
    pb = vsub(b, p);
    pc = vsub(c, p);
    num = vdot(n, pa);
    s = sign_of(den);
    // Edge tests in triple-product form; zero means on the edge and still hits.
    if (sign_of(vdot(vcross(pa, pb), d)) * s < 0 ||
        sign_of(vdot(vcross(pb, pc), d)) * s < 0 ||
        sign_of(vdot(vcross(pc, pa), d)) * s < 0) begin
      return o;
    end
    o.hit = 1'b1;
    o.point_x = hit_coord(p.x, num, den, d.x);
    o.point_y = hit_coord(p.y, num, den, d.y);
    o.point_z = hit_coord(p.z, num, den, d.z);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic logic [VTX_W-1:0] pack_vertex(longint x, longint y, longint z);
    return {coord_t'(x), coord_t'(y), coord_t'(z)};
  endfunction

  function automatic ray_t make_ray(longint ox, longint oy, longint oz,
                                    longint dx, longint dy, longint dz);
    ray_t r;
    r.origin_x = coord_t'(ox);
    r.origin_y = coord_t'(oy);
    r.origin_z = coord_t'(oz);
    r.dir_x = coord_t'(dx);
    r.dir_y = coord_t'(dy);
    r.dir_z = coord_t'(dz);
    return r;
  endfunction

  function automatic coord_t corner_value();
    case ($urandom_range(0, 5))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return coord_t'(0);
      3: return coord_t'(-1);
      4: return coord_t'(1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic longint spread(int range);
    return longint'($urandom_range(0, 2 * range)) - range;
  endfunction

  // Most rays are aimed at a random point of the triangle (edges and vertices
  // included), so the edge tests and the division see real work; the rest are
  // raw random bits or corner values.
  function automatic ray_t random_ray();
    int sel, u, v;
    vec_t a, b, c, t, o, d;
    ray_t r;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      a = vertex_of(vertex_regs[0]);
      b = vertex_of(vertex_regs[1]);
      c = vertex_of(vertex_regs[2]);
      u = $urandom_range(0, 256);
      v = $urandom_range(0, 256 - u);
      t.x = a.x + ((b.x - a.x) * u + (c.x - a.x) * v) / 256;
      t.y = a.y + ((b.y - a.y) * u + (c.y - a.y) * v) / 256;
      t.z = a.z + ((b.z - a.z) * u + (c.z - a.z) * v) / 256;
      o.x = clamp_coord(t.x + spread(4000));
      o.y = clamp_coord(t.y + spread(4000));
      o.z = clamp_coord(t.z + spread(4000));
      d.x = clamp_coord(t.x - o.x);
      d.y = clamp_coord(t.y - o.y);
      d.z = clamp_coord(t.z - o.z);
      // Pointing the ray away from the triangle gives a hit behind the origin.
      if ($urandom_range(0, 3) == 0) begin
        d.x = clamp_coord(-d.x);
        d.y = clamp_coord(-d.y);
        d.z = clamp_coord(-d.z);
      end
      r = make_ray(o.x, o.y, o.z, d.x, d.y, d.z);
    end else if (sel < 85) begin
      r = ray_t'({$urandom, $urandom, $urandom});
    end else begin
      r.origin_x = corner_value();
      r.origin_y = corner_value();
      r.origin_z = corner_value();
      r.dir_x = corner_value();
      r.dir_y = corner_value();
      r.dir_z = corner_value();
    end
    return r;
  endfunction

  // Vertex setting for one phase: degenerate all-zero and all-one registers,
  // triangles built from the coordinate extremes, and moderate random ones.
  function automatic logic [VTX_W-1:0] phase_vertex(int phase);
    case (phase)
      0: return '0;
      1: return '1;
      2, 3: return {corner_value(), corner_value(), corner_value()};
      default: return pack_vertex(spread(8000), spread(8000), spread(8000));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers. Inputs change with nonblocking assignments at the rising
  // edge; ready is sampled at the falling edge, so the rising edge that
  // follows is the one at which the transaction completes.
  // ---------------------------------------------------------------------------

  task automatic write_vertex(logic [CFG_IDX_W-1:0] idx, logic [VTX_W-1:0] value);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    vertex_regs[idx] = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_triangle(logic [VTX_W-1:0] va, logic [VTX_W-1:0] vb,
                              logic [VTX_W-1:0] vc);
    write_vertex(REG_VERTEX_A, va);
    write_vertex(REG_VERTEX_B, vb);
    write_vertex(REG_VERTEX_C, vc);
  endtask

  // Sends one ray and records what it must produce. Returns at the rising edge
  // of its transaction with ray_valid still high.
  task automatic send_ray(ray_t r, bit known, res_t e);
    bit taken;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      ray_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    ray_valid <= 1'b1;
    ray <= r;
    do begin
      @(negedge clk);
      taken = ray_ready;
      @(posedge clk);
    end while (!taken);
    pending_hits.push_back(known ? e : trace_ray(r));
  endtask

  // Lowers the ray channel and waits until every owed result has come back,
  // so the vertex registers may be rewritten.
  task automatic drain_rays();
    ray_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts on res_ready, checks at the falling edge.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_result(res_t got);
    res_t e;
    if (pending_hits.size() == 0) begin
      report_mismatch($sformatf("result %h arrived with no ray outstanding", got));
      return;
    end
    e = pending_hits.pop_front();
    if (got.hit !== e.hit)
      report_mismatch($sformatf("hit got %b want %b", got.hit, e.hit));
    if (got.parallel !== e.parallel)
      report_mismatch($sformatf("parallel got %b want %b", got.parallel, e.parallel));
    if (got.point_x !== e.point_x)
      report_mismatch($sformatf("point_x got %0d want %0d", got.point_x, e.point_x));
    if (got.point_y !== e.point_y)
      report_mismatch($sformatf("point_y got %0d want %0d", got.point_y, e.point_y));
    if (got.point_z !== e.point_z)
      report_mismatch($sformatf("point_z got %0d want %0d", got.point_z, e.point_z));
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        res_ready <= 1'b0;
        stall_left--;
      end else begin
        res_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 7);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (!rst && res_valid && res_ready) check_result(res);
    end
  end

  // Watchdog: any transaction on any channel counts as progress.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk);
      if ((ray_valid && ray_ready) || (res_valid && res_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------

  initial begin
    res_t degen, none;
    int reset_rows;
    logic [VTX_W-1:0] va, vb, vc;
    degen = '0;
    degen.parallel = 1'b1;
    none = '0;
    foreach (vertex_regs[i]) vertex_regs[i] = VERTEX_RESET;

    // With every vertex at its reset value the triangle is a single point,
    // so each ray must come back as parallel with a zero point.
    directed_rays.push_back('{make_ray(0, 0, 0, 0, 0, 0), 1'b1, degen});
    directed_rays.push_back('{make_ray(32767, 32767, 32767, 32767, 32767, 32767), 1'b1, degen});
    directed_rays.push_back('{make_ray(-32768, -32768, -32768, -32768, -32768, -32768),
                              1'b1, degen});
    directed_rays.push_back('{make_ray(-32768, 32767, -1, 32767, -32768, 1), 1'b1, degen});
    directed_rays.push_back('{make_ray(64, 64, 256, 0, 0, -256), 1'b1, degen});
    reset_rows = directed_rays.size();

    // Unit right triangle in the z = 0 plane: A at the origin, B on x, C on y.
    directed_rays.push_back('{make_ray(64, 64, 256, 0, 0, -256), 1'b0, none});     // inside
    directed_rays.push_back('{make_ray(128, 0, 256, 0, 0, -256), 1'b0, none});     // on an edge
    directed_rays.push_back('{make_ray(256, 0, 256, 0, 0, -256), 1'b0, none});     // on a vertex
    directed_rays.push_back('{make_ray(0, 0, 256, 0, 0, -256), 1'b0, none});       // vertex A
    directed_rays.push_back('{make_ray(256, 256, 256, 0, 0, -256), 1'b0, none});   // miss
    directed_rays.push_back('{make_ray(64, 64, -256, 0, 0, -256), 1'b0, none});    // behind origin
    directed_rays.push_back('{make_ray(64, 64, 256, 256, 0, 0), 1'b0, none});      // parallel
    directed_rays.push_back('{make_ray(64, 64, 256, -32768, -32768, -32768), 1'b0, none});
    directed_rays.push_back('{make_ray(0, 0, 1, 1, 1, -3), 1'b0, none});           // rounding
    directed_rays.push_back('{make_ray(1, 1, 2, 0, 0, -32768), 1'b0, none});
    directed_rays.push_back('{make_ray(32767, 32767, 32767, 32767, 32767, 32767), 1'b0, none});
    directed_rays.push_back('{make_ray(-32768, -32768, -32768, 1, 1, 1), 1'b0, none});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rays[i]) begin
      if (i == reset_rows) begin
        drain_rays();
        set_triangle(pack_vertex(0, 0, 0), pack_vertex(256, 0, 0), pack_vertex(0, 256, 0));
      end
      send_ray(directed_rays[i].r, directed_rays[i].known, directed_rays[i].e);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_rays();
      va = phase_vertex(ph);
      vb = phase_vertex(ph);
      vc = phase_vertex(ph);
      set_triangle(va, vb, vc);
      // The last phase runs at full rate on both sides.
      if (ph == NUM_PHASES - 1) idle_on = 1'b0;
      repeat (RAYS_PER_PHASE) send_ray(random_ray(), 1'b0, none);
    end

    drain_rays();
    // Give the pipeline time to show any result it should not have produced.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
